FILE: hdl/kdetlv_pkg.sv
// Shared types and constants for the key-data element search and extract block.
package kdetlv_pkg;

  // Smallest legal element length: OUI plus data type.
  localparam logic [7:0] MIN_LENGTH = 8'd4;

  // Index of the last header byte (type, length, three OUI bytes, data type).
  localparam logic [2:0] HDR_LAST = 3'd5;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SKIP    = 2'd1,
    PH_CAPTURE = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_ELEMENT_TYPE     = 2'd0,
    REG_TARGET_OUI       = 2'd1,
    REG_TARGET_DATA_TYPE = 2'd2,
    REG_CAPTURE_SIZE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  element_type;
    logic [23:0] target_oui;
    logic [7:0]  target_data_type;
    logic [5:0]  capture_size;
  } cfg_t;

  typedef struct packed {
    logic       found;
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic       last_result;
  } result_t;

  // Write request from the parser into the result queue.
  typedef struct packed {
    logic    pending;   // a word sits in the parser input register
    logic    we;        // write entry into the queue
    logic    rollback;  // drop uncommitted entries, write at the commit point
    logic    commit;    // make everything written so far visible to the reader
    result_t entry;
  } wr_req_t;

endpackage

FILE: hdl/kdetlv_in_if.sv
// Input channel: one key-data byte per word.
interface kdetlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

FILE: hdl/kdetlv_out_if.sv
// Output channel: one result (payload byte or not-found) per word.
interface kdetlv_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic       last_result;

  modport source (output valid, found, payload_byte, payload_index, last_result, input ready);
  modport sink (input valid, found, payload_byte, payload_index, last_result, output ready);
endinterface

FILE: hdl/kdetlv_core_top.sv
// Top level of the key-data element search and payload extract block.
//
// Usage: key-data bytes arrive on rx, one byte per word, with last_byte set
// on the final byte of each buffer. Results leave on tx, one per word: either
// a captured payload byte (found set, payload_index counting from zero) or a
// single not-found word. last_result marks the final word of each answer.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle; registers are element type, OUI, data type, capture size.
//
// Throughput is one byte per cycle while rx.ready is high. A byte accepted
// sits in the input register, then updates the parse state and the result
// queue, and, if it completes an answer, its first result word goes on
// through the output register to tx. A captured payload is held uncommitted
// in the queue until its last byte arrives, then drains one word per cycle
// while tx is ready. The queue holds 2*MAX_CAPTURE words, rounded up to a
// power of two; rx.ready drops only when it is nearly full, which happens
// when tx stalls for long. Stalls on tx never lose or repeat words.
// Reset restores the configuration defaults and clears parse state and queue.
module kde_tlv_search_extract_core #(
  parameter int MAX_CAPTURE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  kdetlv_in_if.sink   rx,
  kdetlv_out_if.source tx
);
  import kdetlv_pkg::*;

  cfg_t    cfg;
  wr_req_t wr;
  logic    room;

  // Configuration registers; each write keeps only the register's own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.element_type     <= 8'd221;
      cfg.target_oui       <= 24'd4012;
      cfg.target_data_type <= 8'd1;
      cfg.capture_size     <= 6'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ELEMENT_TYPE:     cfg.element_type     <= cfg_data[7:0];
        REG_TARGET_OUI:       cfg.target_oui       <= cfg_data;
        REG_TARGET_DATA_TYPE: cfg.target_data_type <= cfg_data[7:0];
        REG_CAPTURE_SIZE:     cfg.capture_size     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // The parser walks element headers and feeds the result queue.
  kdetlv_parser #(.MAX_CAPTURE(MAX_CAPTURE)) u_parser (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .room (room),
    .rx   (rx),
    .wr   (wr)
  );

  // The queue releases committed results to the output register.
  kdetlv_fifo #(.MAX_CAPTURE(MAX_CAPTURE)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .room (room),
    .tx   (tx)
  );

endmodule

FILE: hdl/kdetlv_parser.sv
// Element parser: input register, header walk, skip and capture control.
module kdetlv_parser #(
  parameter int MAX_CAPTURE = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  kdetlv_pkg::cfg_t    cfg,
  input  logic                room,
  kdetlv_in_if.sink           rx,
  output kdetlv_pkg::wr_req_t wr
);
  import kdetlv_pkg::*;

  localparam int CW = $clog2(MAX_CAPTURE + 1);
  localparam int SW = (CW > 6) ? CW : 6;

  // Input register.
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;

  // Parse state.
  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic        type_matched, type_matched_next;
  logic [7:0]  element_length, element_length_next;
  logic [23:0] oui_shift, oui_shift_next;
  logic [7:0]  skip_left, skip_left_next;
  logic [CW-1:0] capture_count, capture_count_next;
  logic        answered, answered_next;

  logic [SW-1:0] size_wide;
  logic [CW-1:0] size;
  logic [CW:0]   count_inc;
  logic [7:0]    skip_dec;

  assign rx.ready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= rx.valid && rx.ready;
    end
    if (rx.valid && rx.ready) begin
      stage_byte <= rx.data_byte;
      stage_last <= rx.last_byte;
    end
  end

  // Capture size of zero acts as one; above the store depth it saturates.
  assign size_wide = SW'(cfg.capture_size);
  always_comb begin
    if (size_wide == '0) begin
      size = CW'(1);
    end else if (size_wide > SW'(MAX_CAPTURE)) begin
      size = CW'(MAX_CAPTURE);
    end else begin
      size = CW'(size_wide);
    end
  end

  assign count_inc = {1'b0, capture_count} + (CW + 1)'(1);
  assign skip_dec  = (skip_left != '0) ? skip_left - 8'd1 : skip_left;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    type_matched_next   = type_matched;
    element_length_next = element_length;
    oui_shift_next      = oui_shift;
    skip_left_next      = skip_left;
    capture_count_next  = capture_count;
    answered_next       = answered;

    wr.pending  = stage_valid;
    wr.we       = 1'b0;
    wr.rollback = 1'b0;
    wr.commit   = 1'b0;
    wr.entry    = '0;

    if (stage_valid) begin
      unique case (phase)
        PH_HEADER: begin
          case (header_count) inside
            3'd0:             type_matched_next = (stage_byte == cfg.element_type);
            3'd1:             element_length_next = stage_byte;
            3'd2, 3'd3, 3'd4: oui_shift_next = {oui_shift[15:0], stage_byte};
            default: ;
          endcase
          if (header_count < HDR_LAST) begin
            header_count_next = header_count + 3'd1;
          end else begin
            header_count_next = '0;
            if (type_matched && (oui_shift == cfg.target_oui) &&
                (stage_byte == cfg.target_data_type)) begin
              phase_next         = PH_CAPTURE;
              capture_count_next = '0;
            end else if (element_length < MIN_LENGTH) begin
              // Malformed length answers the buffer at once with not-found.
              wr.we         = 1'b1;
              wr.commit     = 1'b1;
              wr.entry      = '{found: 1'b0, payload_byte: '0, payload_index: '0,
                                last_result: 1'b1};
              answered_next = 1'b1;
              phase_next    = PH_DONE;
            end else begin
              skip_left_next = element_length - MIN_LENGTH;
              phase_next = (element_length == MIN_LENGTH) ? PH_HEADER : PH_SKIP;
            end
            type_matched_next = 1'b0;
            oui_shift_next    = '0;
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_HEADER;
          end
        end
        PH_CAPTURE: begin
          // Captured bytes go into the queue uncommitted until the last one lands.
          wr.we    = 1'b1;
          wr.entry = '{found: 1'b1, payload_byte: stage_byte,
                       payload_index: 5'(capture_count),
                       last_result: (count_inc == {1'b0, size})};
          capture_count_next = count_inc[CW-1:0];
          if (count_inc >= {1'b0, size}) begin
            wr.commit     = 1'b1;
            answered_next = 1'b1;
            phase_next    = PH_DONE;
          end
        end
        PH_DONE: ;
        default: ;
      endcase

      if (stage_last) begin
        if (!answered_next) begin
          // Unanswered buffer: discard any partial capture and report not-found.
          wr.we       = 1'b1;
          wr.rollback = 1'b1;
          wr.commit   = 1'b1;
          wr.entry    = '{found: 1'b0, payload_byte: '0, payload_index: '0,
                          last_result: 1'b1};
        end
        phase_next          = PH_HEADER;
        header_count_next   = '0;
        type_matched_next   = 1'b0;
        element_length_next = '0;
        oui_shift_next      = '0;
        skip_left_next      = '0;
        capture_count_next  = '0;
        answered_next       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      type_matched   <= 1'b0;
      element_length <= '0;
      oui_shift      <= '0;
      skip_left      <= '0;
      capture_count  <= '0;
      answered       <= 1'b0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      type_matched   <= type_matched_next;
      element_length <= element_length_next;
      oui_shift      <= oui_shift_next;
      skip_left      <= skip_left_next;
      capture_count  <= capture_count_next;
      answered       <= answered_next;
    end
  end

endmodule

FILE: hdl/kdetlv_fifo.sv
// Result queue with speculative write, commit and rollback, plus output register.
module kdetlv_fifo #(
  parameter int MAX_CAPTURE = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  kdetlv_pkg::wr_req_t wr,
  output logic                room,
  kdetlv_out_if.source        tx
);
  import kdetlv_pkg::*;

  localparam int AW    = $clog2(2 * MAX_CAPTURE);
  localparam int DEPTH = 1 << AW;

  result_t mem [DEPTH];

  logic [AW:0] spec_ptr, commit_ptr, rd_ptr;
  logic [AW:0] wr_addr, spec_after;
  logic [AW:0] occupancy;
  logic [AW+1:0] demand;
  logic        pop;
  logic        out_valid;
  result_t     out_word;

  assign wr_addr    = wr.rollback ? commit_ptr : spec_ptr;
  assign spec_after = wr.we ? wr_addr + (AW + 1)'(1) : spec_ptr;
  assign occupancy  = spec_ptr - rd_ptr;
  // Leave space for the word in the parser input register and the next one.
  assign demand     = {1'b0, occupancy} + (AW + 2)'(wr.pending);
  assign room       = demand < (AW + 2)'(DEPTH);
  assign pop        = (!out_valid || tx.ready) && (commit_ptr != rd_ptr);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr[AW-1:0]] <= wr.entry;
    end
    if (pop) begin
      out_word <= mem[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spec_ptr   <= '0;
      commit_ptr <= '0;
      rd_ptr     <= '0;
      out_valid  <= 1'b0;
    end else begin
      spec_ptr <= spec_after;
      if (wr.commit) begin
        commit_ptr <= spec_after;
      end
      if (pop) begin
        rd_ptr    <= rd_ptr + (AW + 1)'(1);
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tx.valid         = out_valid;
  assign tx.found         = out_word.found;
  assign tx.payload_byte  = out_word.payload_byte;
  assign tx.payload_index = out_word.payload_index;
  assign tx.last_result   = out_word.last_result;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (AW + 1)'(DEPTH))
    else $error("result queue overfilled");

  a_commit_inside: assert property (@(posedge clk) disable iff (rst)
    (commit_ptr - rd_ptr) <= occupancy)
    else $error("commit point outside written entries");

  a_commit_catches_up: assert property (@(posedge clk) disable iff (rst)
    wr.commit |=> commit_ptr == spec_ptr)
    else $error("commit did not cover all written entries");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (wr.we && !wr.rollback) |-> occupancy < (AW + 1)'(DEPTH))
    else $error("write into full result queue");
`endif

endmodule
